[sv/gdcf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gdcf_pkg
// Shared types, register map and helper functions of the greedy domain
// coverage filter.
// ----------------------------------------------------------------------------
package gdcf_pkg;

   localparam int MAX_LEN_DEFAULT = 65536;

   localparam int POS_W    = 16;
   localparam int COV_W    = 11;
   localparam int WORD_W   = 64;
   localparam int WIDX_W   = POS_W - 6;
   localparam int CNT_W    = POS_W;
   localparam int SPAN1_W  = POS_W + 1;
   localparam int PROD_W   = COV_W + SPAN1_W;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   // register map, indexed by paddr[2]
   localparam logic REG_COVERAGE = 1'b0;
   localparam logic REG_OVERLAP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_KEPT    = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_LOW_COV = 2'd2,
      STATUS_OVERLAP = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CLEAR  = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_COUNT  = 7'b0001000,
      ST_DECIDE = 7'b0010000,
      ST_MARK   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

   function automatic logic [6:0] popcount64(input logic [WORD_W-1:0] v);
      logic [6:0] n;
      n = 7'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, popcount8(v[8*i +: 8])};
      end
      return n;
   endfunction

endpackage
`default_nettype wire

[sv/greedy_domain_coverage_filter_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_domain_coverage_filter_core
// Keeps an alignment record only when the query positions it spans are not
// already mostly covered by records kept earlier in the same query.
// ----------------------------------------------------------------------------
// One word in, one word out. The coverage bitmap sits in a single memory of
// 64-bit rows (one row per 64 query positions) with one read and one write
// port; one popcount/merge unit walks it one row per cycle. A record that
// fails the range or coverage check skips both walks, and an empty span goes
// straight to the decision. Otherwise a record dropped for overlap runs only the
// count walk over the rows its span touches, and a kept record runs the count
// walk and then the mark walk. A record with first_of_query set first clears
// the whole bitmap. A verdict word still waiting on the output keeps the
// current record in ST_FINISH and so holds off the next one. After reset the
// same clearing pass runs before the first word is taken; register writes are
// taken throughout.
// ----------------------------------------------------------------------------
module greedy_domain_coverage_filter_core
   import gdcf_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,

   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_first_of_query,
   input  wire [POS_W-1:0]     req_query_start,
   input  wire [POS_W-1:0]     req_query_end,
   input  wire [POS_W-1:0]     req_query_length,
   input  wire [COV_W-1:0]     req_target_coverage,

   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic                rsp_keep,
   output logic [1:0]          rsp_status,

   input  wire                 psel,
   input  wire                 penable,
   input  wire                 pwrite,
   input  wire [PADDR_W-1:0]   paddr,
   input  wire [PDATA_W-1:0]   pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   localparam int WORDS = (MAX_LEN + WORD_W - 1) / WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   // registers
   logic [COV_W-1:0] cov_thr_ff, ovl_thr_ff;

   // control
   state_type        state_ff, state_in;
   logic             pending_ff, pending_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             issue_ff, issue_in;
   logic             dat_vld_ff, dat_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath
   logic             first_ff, first_in;
   logic [POS_W-1:0] qs_ff, qs_in, qe_ff, qe_in, ql_ff, ql_in;
   logic [POS_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [COV_W-1:0] cov_ff, cov_in;
   logic [WIDX_W-1:0] rd_idx_ff, rd_idx_in, dat_idx_ff, dat_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   status_type       status_ff, status_in;
   logic             rsp_keep_ff, rsp_keep_in;
   status_type       rsp_status_ff, rsp_status_in;

   // memory
   logic [WORD_W-1:0] bitmap_mem [WORDS];
   logic [WORD_W-1:0] mem_q_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;

   logic [POS_W-1:0]   hi_m1;
   logic [WIDX_W-1:0]  lo_word, hi_word;
   logic [6:0]         a_lim, b_lim;
   logic [WORD_W-1:0]  row_mask;
   logic [SPAN1_W-1:0] span1;
   logic               in_accept, range_bad, walk_done;

   // ---------------------------------------------------------------- config
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cov_thr_ff <= '0;
         ovl_thr_ff <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_COVERAGE) begin
            cov_thr_ff <= pwdata[COV_W-1:0];
         end else begin
            ovl_thr_ff <= pwdata[COV_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_COVERAGE) begin
         prdata = {{(PDATA_W-COV_W){1'b0}}, cov_thr_ff};
      end else begin
         prdata = {{(PDATA_W-COV_W){1'b0}}, ovl_thr_ff};
      end
   end

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= bitmap_mem[rd_addr];
   end

   // -------------------------------------------------------------- row unit
   assign hi_m1   = hi_ff - POS_W'(1);
   assign lo_word = lo_ff[POS_W-1:6];
   assign hi_word = hi_m1[POS_W-1:6];
   assign span1   = {1'b0, hi_ff} - {1'b0, lo_ff} + SPAN1_W'(1);
   assign rd_addr = AW'(rd_idx_ff);

   always_comb begin
      a_lim = (dat_idx_ff == lo_word) ? {1'b0, lo_ff[5:0]} : 7'd0;
      b_lim = (dat_idx_ff == hi_word) ? ({1'b0, hi_m1[5:0]} + 7'd1) : 7'd64;
      for (int i = 0; i < WORD_W; i++) begin
         row_mask[i] = (7'(i) >= a_lim) && (7'(i) < b_lim);
      end
   end

   assign walk_done = !issue_ff && !dat_vld_ff;
   assign range_bad = (qs_ff > ql_ff) || (qe_ff > ql_ff) || (32'(ql_ff) > 32'(MAX_LEN));
   assign in_accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      clr_in        = clr_ff;
      issue_in      = issue_ff;
      dat_vld_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      dat_idx_in    = rd_idx_ff;
      first_in      = first_ff;
      qs_in         = qs_ff;
      qe_in         = qe_ff;
      ql_in         = ql_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cov_in        = cov_ff;
      count_in      = count_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_keep_in   = rsp_keep_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(dat_idx_ff);
      wr_data       = mem_q_ff | row_mask;

      if ((state_ff == ST_COUNT || state_ff == ST_MARK) && issue_ff) begin
         dat_vld_in = 1'b1;
         if (rd_idx_ff == hi_word) begin
            issue_in = 1'b0;
         end else begin
            rd_idx_in = rd_idx_ff + WIDX_W'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               first_in   = req_first_of_query;
               qs_in      = req_query_start;
               qe_in      = req_query_end;
               ql_in      = req_query_length;
               cov_in     = req_target_coverage;
               lo_in      = (req_query_start < req_query_end) ? req_query_start
                                                               : req_query_end;
               hi_in      = (req_query_start < req_query_end) ? req_query_end
                                                               : req_query_start;
               pending_in = 1'b1;
               clr_in     = '0;
               state_in   = req_first_of_query ? ST_CLEAR : ST_CHECK;
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = pending_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            count_in  = '0;
            prod_in   = PROD_W'(ovl_thr_ff) * PROD_W'(span1);
            rd_idx_in = lo_word;
            issue_in  = 1'b1;
            if (range_bad) begin
               status_in = STATUS_RANGE;
               state_in  = ST_FINISH;
            end else if (cov_ff <= cov_thr_ff) begin
               status_in = STATUS_LOW_COV;
               state_in  = ST_FINISH;
            end else if (hi_ff == lo_ff) begin
               state_in  = ST_DECIDE;
            end else begin
               state_in  = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (dat_vld_ff) begin
               count_in = count_ff + CNT_W'(popcount64(mem_q_ff & row_mask));
            end
            if (walk_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            rd_idx_in = lo_word;
            issue_in  = 1'b1;
            if ({2'b00, count_ff, 10'b0} <= prod_ff) begin
               status_in = STATUS_KEPT;
               state_in  = (hi_ff == lo_ff) ? ST_FINISH : ST_MARK;
            end else begin
               status_in = STATUS_OVERLAP;
               state_in  = ST_FINISH;
            end
         end
         ST_MARK: begin
            wr_en = dat_vld_ff;
            if (walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_keep_in   = (status_ff == STATUS_KEPT);
               rsp_status_in = status_ff;
               pending_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pending_ff   <= 1'b0;
         clr_ff       <= '0;
         issue_ff     <= 1'b0;
         dat_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         dat_vld_ff   <= dat_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      qs_ff         <= qs_in;
      qe_ff         <= qe_in;
      ql_ff         <= ql_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cov_ff        <= cov_in;
      rd_idx_ff     <= rd_idx_in;
      dat_idx_ff    <= dat_idx_in;
      count_ff      <= count_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      rsp_keep_ff   <= rsp_keep_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_keep   = rsp_keep_ff;
   assign rsp_status = rsp_status_ff;

   // ------------------------------------------------------------ assertions
   a_keep_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_keep == (rsp_status == STATUS_KEPT)))
      else $error("keep disagrees with status");

   a_mark_only_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (status_ff == STATUS_KEPT))
      else $error("marking a record that was not kept");

   a_count_within_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> ({1'b0, count_ff} < span1))
      else $error("covered count exceeds span");

   a_clear_only_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && pending_ff) |-> first_ff)
      else $error("bitmap clear without first_of_query");

endmodule
`default_nettype wire

[tb/greedy_domain_coverage_filter_checker.sv]
// ----------------------------------------------------------------------------
// greedy_domain_coverage_filter_checker
// Watches the record and verdict channels and the register port of the
// coverage filter. Keeps its own coverage bitmap and thresholds, judges each
// accepted record word as it goes in, and compares each verdict word that
// comes out with the oldest judgment still due. Counts mismatches for the
// testbench top.
// ----------------------------------------------------------------------------
module greedy_domain_coverage_filter_checker
   import gdcf_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,

   input  wire                 req_valid,
   input  wire                 req_stall,
   input  wire                 req_first_of_query,
   input  wire [POS_W-1:0]     req_query_start,
   input  wire [POS_W-1:0]     req_query_end,
   input  wire [POS_W-1:0]     req_query_length,
   input  wire [COV_W-1:0]     req_target_coverage,

   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  wire                 rsp_keep,
   input  wire [1:0]           rsp_status,

   input  wire                 psel,
   input  wire                 penable,
   input  wire                 pwrite,
   input  wire [PADDR_W-1:0]   paddr,
   input  wire [PDATA_W-1:0]   pwdata,
   input  wire                 pready,

   output int                  mismatch_count,
   output int                  verdicts_due
);

   localparam int ROWS   = (MAX_LEN + WORD_W - 1) / WORD_W;
   localparam int ONE_Q10 = 1024;

   typedef struct packed {
      logic       keep;
      status_type status;
   } verdict_type;

   logic [WORD_W-1:0] taken_rows [ROWS];
   logic [COV_W-1:0]  min_coverage;
   logic [COV_W-1:0]  max_overlap;
   verdict_type       due_verdicts [$];

   function automatic verdict_type judge_record(input logic             first,
                                                input logic [POS_W-1:0] qs,
                                                input logic [POS_W-1:0] qe,
                                                input logic [POS_W-1:0] ql,
                                                input logic [COV_W-1:0] cov);
      int unsigned       lo;
      int unsigned       hi;
      longint unsigned   hits;
      longint unsigned   span1;
      verdict_type       v;
      hits = 0;
      if (first) begin
         foreach (taken_rows[r]) taken_rows[r] = '0;
      end
      lo = (qs < qe) ? qs : qe;
      hi = (qs < qe) ? qe : qs;
      span1 = hi - lo + 1;
      if (qs > ql || qe > ql || int'(ql) > MAX_LEN) begin
         v.status = STATUS_RANGE;
      end else if (cov <= min_coverage) begin
         v.status = STATUS_LOW_COV;
      end else begin
         for (int unsigned p = lo; p < hi && p < MAX_LEN; p++) begin
            hits += taken_rows[p / WORD_W][p % WORD_W];
         end
         if (hits * ONE_Q10 <= longint'(max_overlap) * span1) begin
            v.status = STATUS_KEPT;
            for (int unsigned p = lo; p < hi && p < MAX_LEN; p++) begin
               taken_rows[p / WORD_W][p % WORD_W] = 1'b1;
            end
         end else begin
            v.status = STATUS_OVERLAP;
         end
      end
      v.keep = (v.status == STATUS_KEPT);
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type due;
      if (reset) begin
         foreach (taken_rows[r]) taken_rows[r] = '0;
         min_coverage = '0;
         max_overlap = '0;
         due_verdicts.delete();
         mismatch_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               {REG_COVERAGE, 2'b00}: min_coverage = pwdata[COV_W-1:0];
               {REG_OVERLAP, 2'b00}:  max_overlap = pwdata[COV_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_verdicts.size() == 0) begin
               $error("verdict word with no record pending: keep %0d status %0d",
                      rsp_keep, rsp_status);
               mismatch_count++;
            end else begin
               due = due_verdicts.pop_front();
               if (rsp_keep !== due.keep) begin
                  $error("keep: expected %0d, got %0d", due.keep, rsp_keep);
                  mismatch_count++;
               end
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_verdicts.insert(due_verdicts.size(),
                                judge_record(req_first_of_query, req_query_start,
                                             req_query_end, req_query_length,
                                             req_target_coverage));
         end
      end
      verdicts_due = due_verdicts.size();
   end

endmodule

[tb/greedy_domain_coverage_filter_core_tb.sv]
// ----------------------------------------------------------------------------
// greedy_domain_coverage_filter_core_tb
// Drives the coverage filter with directed records (range, coverage and
// overlap rejections, empty spans, bitmap clears, the inclusive overlap
// bound, full-range spans) and then with random query groups under several
// threshold settings and idling phases, including one long receiver hold-off.
// The checker beside the block judges every record and compares verdicts.
// ----------------------------------------------------------------------------
module greedy_domain_coverage_filter_core_tb;
   import gdcf_pkg::*;

   localparam int LIMIT_CYCLES    = 3_000_000;
   localparam int HOLD_OFF_CYCLES = 2500;
   localparam int DRAIN_CYCLES    = 3200;
   localparam int PHASES          = 8;
   localparam int RANDOM_SETTING  = -1;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_first_of_query = 1'b0;
   logic [POS_W-1:0]    req_query_start = '0;
   logic [POS_W-1:0]    req_query_end = '0;
   logic [POS_W-1:0]    req_query_length = '0;
   logic [COV_W-1:0]    req_target_coverage = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_keep;
   logic [1:0]          rsp_status;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   int mismatches;
   int verdicts_due;
   int cycle_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   bit start_hold = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;
   int records_sent = 0;
   int queries_started = 0;
   int settings_used = 0;

   int phase_cov   [PHASES] = '{0, 300, 1024, 2047, 100, RANDOM_SETTING, 0, RANDOM_SETTING};
   int phase_ovl   [PHASES] = '{0, 512, 1024, 2047, 2047, RANDOM_SETTING, 100, RANDOM_SETTING};
   int phase_items [PHASES] = '{75, 75, 75, 30, 75, 75, 75, 75};

   greedy_domain_coverage_filter_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_of_query  (req_first_of_query),
      .req_query_start     (req_query_start),
      .req_query_end       (req_query_end),
      .req_query_length    (req_query_length),
      .req_target_coverage (req_target_coverage),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_keep            (rsp_keep),
      .rsp_status          (rsp_status),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   greedy_domain_coverage_filter_checker chk (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_of_query  (req_first_of_query),
      .req_query_start     (req_query_start),
      .req_query_end       (req_query_end),
      .req_query_length    (req_query_length),
      .req_target_coverage (req_target_coverage),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_keep            (rsp_keep),
      .rsp_status          (rsp_status),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .pready              (pready),
      .mismatch_count      (mismatches),
      .verdicts_due        (verdicts_due)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d verdicts still due", cycle_count,
                  verdicts_due);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver side: random stall, or one long hold-off on request
   always @(negedge clock) begin
      if (start_hold && !hold_taken) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin gap_pct = 69; stall_pct = 0;  end
         IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 69; end
         IDLE_BOTH:     begin gap_pct = 28; stall_pct = 28; end
         default:       begin gap_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [COV_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= ($urandom() & ~32'h7FF) | PDATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // drain, then load both thresholds
   task automatic set_thresholds(input logic [COV_W-1:0] cov, input logic [COV_W-1:0] ovl);
      req_valid <= 1'b0;
      while (verdicts_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      write_reg({REG_COVERAGE, 2'b00}, cov);
      write_reg({REG_OVERLAP, 2'b00}, ovl);
      settings_used++;
   endtask

   task automatic send_record(input logic             first,
                              input logic [POS_W-1:0] qs,
                              input logic [POS_W-1:0] qe,
                              input logic [POS_W-1:0] ql,
                              input logic [COV_W-1:0] cov);
      int gap;
      gap = 0;
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_first_of_query <= first;
      req_query_start <= qs;
      req_query_end <= qe;
      req_query_length <= ql;
      req_target_coverage <= cov;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      records_sent++;
      if (first) queries_started++;
   endtask

   // one query group: mostly in-range records on short spans, some noise
   task automatic send_query(input int budget, output int sent);
      int   ql;
      int   span;
      int   base;
      int   qs;
      int   qe;
      int   tmp;
      int   cov;
      int   pick;
      int   nrec;
      logic first;
      pick = $urandom_range(99);
      if (pick < 70) ql = $urandom_range(1200, 64);
      else if (pick < 85) ql = 65535 - $urandom_range(40);
      else ql = $urandom_range(65535);
      nrec = $urandom_range(8, 2);
      if (nrec > budget) nrec = budget;
      for (int r = 0; r < nrec; r++) begin
         first = (r == 0) ? ($urandom_range(19) != 0) : ($urandom_range(39) == 0);
         pick = $urandom_range(99);
         if (pick < 5) span = 0;
         else if (pick < 90) span = $urandom_range(ql < 300 ? ql : 300);
         else span = $urandom_range(ql);
         base = $urandom_range(ql - span);
         qs = base;
         qe = base + span;
         if ($urandom_range(1)) begin
            tmp = qs;
            qs = qe;
            qe = tmp;
         end
         if ($urandom_range(99) < 8 && ql < 65535) begin
            if ($urandom_range(1)) qs = $urandom_range(65535, ql + 1);
            else qe = $urandom_range(65535, ql + 1);
         end
         if ($urandom_range(99) < 85) cov = $urandom_range(1024);
         else cov = $urandom_range(2047, 1025);
         send_record(first, POS_W'(qs), POS_W'(qe), POS_W'(ql), COV_W'(cov));
      end
      sent = nrec;
   endtask

   initial begin
      int sent;
      int done;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idle(IDLE_NONE);
      set_thresholds(512, 256);
      send_record(1, 0, 0, 0, 1024);
      send_record(0, 10, 100, 200, 1024);
      send_record(0, 100, 10, 200, 1024);
      send_record(0, 50, 150, 200, 600);
      send_record(0, 90, 200, 200, 513);
      send_record(0, 0, 5, 200, 512);
      send_record(0, 201, 5, 200, 1024);
      send_record(0, 5, 300, 200, 0);
      send_record(0, 150, 160, 200, 100);
      send_record(1, 300, 10, 200, 2047);
      send_record(0, 10, 100, 200, 1024);
      send_record(1, 500, 501, 1000, 1024);
      send_record(0, 499, 502, 1000, 1024);
      send_record(0, 502, 498, 1000, 1024);
      send_record(1, 65000, 65535, 65535, 1024);
      send_record(1, 200, 0, 100, 1024);
      send_record(0, 65535, 65000, 65535, 1024);
      send_record(0, 65535, 65535, 65535, 2047);
      send_record(1, 65535, 0, 65535, 1025);
      send_record(0, 0, 65535, 65535, 1024);
      send_record(0, 65534, 1, 65535, 1);

      for (int ph = 0; ph < PHASES; ph++) begin
         set_thresholds(phase_cov[ph] == RANDOM_SETTING ? COV_W'($urandom_range(1024))
                                                        : COV_W'(phase_cov[ph]),
                        phase_ovl[ph] == RANDOM_SETTING ? COV_W'($urandom_range(1024))
                                                        : COV_W'(phase_ovl[ph]));
         set_idle(idle_mode_type'(ph % 4));
         if (ph == 4) start_hold = 1'b1;
         done = 0;
         while (done < phase_items[ph]) begin
            send_query(phase_items[ph] - done, sent);
            done += sent;
         end
      end

      req_valid <= 1'b0;
      while (verdicts_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d records in %0d query groups under %0d threshold settings",
               records_sent, queries_started, settings_used);
      $display("idling phases covered sender gaps, receiver stalls and one %0d-cycle hold-off",
               HOLD_OFF_CYCLES);
      if (mismatches == 0 && verdicts_due == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[files.f]
sv/gdcf_pkg.sv
sv/greedy_domain_coverage_filter_core.sv
tb/greedy_domain_coverage_filter_checker.sv
tb/greedy_domain_coverage_filter_core_tb.sv
